[rtl/modular_exponentiation_core_defines.svh]
// assertion macros shared by the modular exponentiation checkers
// expects clk and rst_n in the scope of every use
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// same-cycle implication, skipped while reset is low
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped while reset is low
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mexp_pkg.sv]
// shared types, constants and microcode table of the modular exponentiation core
// no dependencies
`default_nettype none

package mexp_pkg;

  // operand width used inside the datapath; port fields stay 32 bits
  localparam int OP_W        = 32;
  localparam int CNT_W       = $clog2(OP_W);
  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 1;

  // microcode step addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_REDUCE = 3'd2;
  localparam logic [STEP_W-1:0] STEP_INIT   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SQUARE = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MULT   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NEXT   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd7;

  // operations
  localparam logic [2:0] OP_WAIT_IN  = 3'd0;
  localparam logic [2:0] OP_CHECK    = 3'd1;
  localparam logic [2:0] OP_INIT     = 3'd2;
  localparam logic [2:0] OP_MUL      = 3'd3;
  localparam logic [2:0] OP_NEXT_BIT = 3'd4;
  localparam logic [2:0] OP_EMIT     = 3'd5;

  // multiplier operand selects and destination
  localparam logic       ASEL_BASE = 1'b0;
  localparam logic       ASEL_ACC  = 1'b1;
  localparam logic [1:0] BSEL_ONE  = 2'd0;
  localparam logic [1:0] BSEL_ACC  = 2'd1;
  localparam logic [1:0] BSEL_BRED = 2'd2;
  localparam logic       DST_ACC   = 1'b0;
  localparam logic       DST_BRED  = 1'b1;

  // jump conditions
  localparam logic [2:0] COND_NONE      = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_MOD_ZERO  = 3'd2;
  localparam logic [2:0] COND_BIT_CLEAR = 3'd3;
  localparam logic [2:0] COND_MORE_BITS = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic              asel;
    logic [1:0]        bsel;
    logic              dst;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic mul_done;
    logic out_free;
    logic mod_zero;
    logic exp_bit;
    logic more_bits;
  } status_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_WAIT_IN, asel: ASEL_ACC, bsel: BSEL_ONE, dst: DST_ACC,
          cond: COND_NONE, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.op = OP_WAIT_IN;
      end
      STEP_CHECK: begin
        w.op     = OP_CHECK;
        w.cond   = COND_MOD_ZERO;
        w.target = STEP_EMIT;
      end
      STEP_REDUCE: begin
        w.op   = OP_MUL;
        w.asel = ASEL_BASE;
        w.bsel = BSEL_ONE;
        w.dst  = DST_BRED;
      end
      STEP_INIT: begin
        w.op = OP_INIT;
      end
      STEP_SQUARE: begin
        w.op     = OP_MUL;
        w.asel   = ASEL_ACC;
        w.bsel   = BSEL_ACC;
        w.dst    = DST_ACC;
        w.cond   = COND_BIT_CLEAR;
        w.target = STEP_NEXT;
      end
      STEP_MULT: begin
        w.op   = OP_MUL;
        w.asel = ASEL_ACC;
        w.bsel = BSEL_BRED;
        w.dst  = DST_ACC;
      end
      STEP_NEXT: begin
        w.op     = OP_NEXT_BIT;
        w.cond   = COND_MORE_BITS;
        w.target = STEP_SQUARE;
      end
      STEP_EMIT: begin
        w.op     = OP_EMIT;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.op = OP_WAIT_IN;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/mexp_mulmod.sv]
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
// depends on mexp_pkg
`default_nettype none

module mexp_mulmod (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [mexp_pkg::OP_W-1:0]  a_in,
  input  wire logic [mexp_pkg::OP_W-1:0]  b_in,   // must not exceed m_in
  input  wire logic [mexp_pkg::OP_W-1:0]  m_in,
  output logic                            done,
  output logic [mexp_pkg::OP_W-1:0]       result
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [mexp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [mexp_pkg::OP_W-1:0]      a_r, a_nxt;
  logic [mexp_pkg::OP_W-1:0]      b_r, b_nxt;
  logic [mexp_pkg::OP_W-1:0]      m_r, m_nxt;
  logic [mexp_pkg::OP_W-1:0]      r_r, r_nxt;
  logic [mexp_pkg::OP_W:0]        dbl, red1, sum, red2, m_ext;

  // r = 2r mod m, then r = r + bit*b mod m
  always_comb begin
    m_ext = {1'b0, m_r};
    dbl   = {r_r, 1'b0};
    red1  = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum   = red1 + (a_r[mexp_pkg::OP_W-1] ? {1'b0, b_r} : '0);
    red2  = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mexp_pkg::CNT_W'(mexp_pkg::OP_W - 1);
      a_nxt    = a_in;
      b_nxt    = b_in;
      m_nxt    = m_in;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt = red2[mexp_pkg::OP_W-1:0];
      a_nxt = {a_r[mexp_pkg::OP_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    r_r   <= r_nxt;
  end

  assign done   = done_r;
  assign result = r_r;

endmodule

`default_nettype wire

[rtl/mexp_sequencer.sv]
// microcode sequencer: step counter, control word lookup and conditional jumps
// depends on mexp_pkg (control word table and status struct)
`default_nettype none

module mexp_sequencer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mexp_pkg::status_t status,
  output mexp_pkg::uword_t       uword
);

  logic [mexp_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        go;
  logic                        taken;

  assign uword = mexp_pkg::ucode(step_r);

  // a step ends when what it waits on is there
  always_comb begin
    case (uword.op)
      mexp_pkg::OP_WAIT_IN: go = status.in_valid;
      mexp_pkg::OP_MUL:     go = status.mul_done;
      mexp_pkg::OP_EMIT:    go = status.out_free;
      default:              go = 1'b1;
    endcase
  end

  always_comb begin
    case (uword.cond)
      mexp_pkg::COND_ALWAYS:    taken = 1'b1;
      mexp_pkg::COND_MOD_ZERO:  taken = status.mod_zero;
      mexp_pkg::COND_BIT_CLEAR: taken = !status.exp_bit;
      mexp_pkg::COND_MORE_BITS: taken = status.more_bits;
      default:                  taken = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (go) begin
      step_nxt = taken ? uword.target : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= mexp_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/modular_exponentiation_core.sv]
// modular exponentiation core: top level with operand registers and output word register
// depends on mexp_pkg, mexp_sequencer and mexp_mulmod
`default_nettype none

// computes base_value ^ power mod divisor by left-to-right square and multiply.
// one input word is taken, then the block works on it alone: a zero divisor
// returns residue 0 with bad_modulus set; otherwise the base is first reduced
// by one modular multiply, then each of the 32 exponent bits costs a squaring
// and a bookkeeping step plus, for a set bit, a multiply by the reduced base.
// every modular multiply runs on one shared bit-serial unit at one bit per
// cycle. the result sits in an output register, so the next input word is
// accepted while a finished result still waits for out_tready.
module modular_exponentiation_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [mexp_pkg::IN_TDATA_W-1:0]      in_tdata,   // base_value, power, divisor
  // result channel
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [mexp_pkg::OUT_TDATA_W-1:0]          out_tdata,  // residue
  output logic [mexp_pkg::OUT_TUSER_W-1:0]          out_tuser   // bad_modulus
);

  mexp_pkg::uword_t   uword;
  mexp_pkg::status_t  status;

  // operand and working registers
  logic [mexp_pkg::OP_W-1:0]        base_r, base_nxt;
  logic [mexp_pkg::OP_W-1:0]        exp_r, exp_nxt;
  logic [mexp_pkg::OP_W-1:0]        mod_r, mod_nxt;
  logic [mexp_pkg::OP_W-1:0]        acc_r, acc_nxt;
  logic [mexp_pkg::OP_W-1:0]        bred_r, bred_nxt;   // base reduced mod divisor
  logic [mexp_pkg::CNT_W-1:0]       bit_r, bit_nxt;     // exponent bit under work
  logic                             err_r, err_nxt;
  logic                             mul_issued_r, mul_issued_nxt;

  // output word register
  logic                             out_valid_r, out_valid_nxt;
  logic [mexp_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                             out_bad_r, out_bad_nxt;

  // multiplier hookup
  logic                             mul_start;
  logic                             mul_done;
  logic [mexp_pkg::OP_W-1:0]        mul_a, mul_b, mul_result;

  logic                             in_fire;
  logic                             out_free;

  assign in_tready = (uword.op == mexp_pkg::OP_WAIT_IN);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign status.in_valid  = in_tvalid;
  assign status.mul_done  = mul_done;
  assign status.out_free  = out_free;
  assign status.mod_zero  = (mod_r == '0);
  assign status.exp_bit   = exp_r[bit_r];
  assign status.more_bits = (bit_r != '0);

  mexp_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .uword  (uword)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_a = (uword.asel == mexp_pkg::ASEL_BASE) ? base_r : acc_r;
    case (uword.bsel)
      mexp_pkg::BSEL_ONE:  mul_b = mexp_pkg::OP_W'(1);
      mexp_pkg::BSEL_ACC:  mul_b = acc_r;
      mexp_pkg::BSEL_BRED: mul_b = bred_r;
      default:             mul_b = mexp_pkg::OP_W'(1);
    endcase
  end

  // one start pulse per multiply step, cleared when its result lands
  assign mul_start = (uword.op == mexp_pkg::OP_MUL) && !mul_issued_r;

  mexp_mulmod u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a_in   (mul_a),
    .b_in   (mul_b),
    .m_in   (mod_r),
    .done   (mul_done),
    .result (mul_result)
  );

  always_comb begin
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    mod_nxt        = mod_r;
    acc_nxt        = acc_r;
    bred_nxt       = bred_r;
    bit_nxt        = bit_r;
    err_nxt        = err_r;
    mul_issued_nxt = mul_issued_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_bad_nxt    = out_bad_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (uword.op)
      mexp_pkg::OP_WAIT_IN: begin
        if (in_fire) begin
          // only the low operand bits of each field take part
          base_nxt = in_tdata[0 +: mexp_pkg::OP_W];
          exp_nxt  = in_tdata[mexp_pkg::FIELD_W +: mexp_pkg::OP_W];
          mod_nxt  = in_tdata[2*mexp_pkg::FIELD_W +: mexp_pkg::OP_W];
        end
      end
      mexp_pkg::OP_CHECK: begin
        err_nxt = (mod_r == '0);
      end
      mexp_pkg::OP_INIT: begin
        // 1 mod divisor, which is zero for a divisor of one
        acc_nxt = (mod_r == mexp_pkg::OP_W'(1)) ? '0 : mexp_pkg::OP_W'(1);
        bit_nxt = mexp_pkg::CNT_W'(mexp_pkg::OP_W - 1);
      end
      mexp_pkg::OP_MUL: begin
        if (mul_start) begin
          mul_issued_nxt = 1'b1;
        end
        if (mul_done) begin
          mul_issued_nxt = 1'b0;
          if (uword.dst == mexp_pkg::DST_BRED) begin
            bred_nxt = mul_result;
          end else begin
            acc_nxt = mul_result;
          end
        end
      end
      mexp_pkg::OP_NEXT_BIT: begin
        bit_nxt = bit_r - 1'b1;
      end
      mexp_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = err_r ? '0 : mexp_pkg::OUT_TDATA_W'(acc_r);
          out_bad_nxt   = err_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      mul_issued_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      mul_issued_r <= mul_issued_nxt;
    end
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    mod_r      <= mod_nxt;
    acc_r      <= acc_nxt;
    bred_r     <= bred_nxt;
    bit_r      <= bit_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_bad_r;

endmodule

`default_nettype wire

[rtl/mexp_checker.sv]
// port-level checks of the modular exponentiation core, bound to the top level
// depends on mexp_pkg and modular_exponentiation_core_defines.svh
`default_nettype none

`include "modular_exponentiation_core_defines.svh"

module mexp_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tvalid,
  input wire logic                                 in_tready,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [mexp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input wire logic [mexp_pkg::OUT_TUSER_W-1:0]     out_tuser
);

  // a stalled result word holds
  `MEXP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  // a zero divisor always reports a zero residue
  `MEXP_ASSERT_NOW(a_bad_zero, out_tvalid && out_tuser[0], out_tdata == '0, "bad modulus with nonzero residue")

  // one item at a time: busy right after taking a word
  `MEXP_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready, "second word taken while busy")

  // a fresh result means the core is back to taking input
  `MEXP_ASSERT_NOW(a_ready_on_result, $rose(out_tvalid), in_tready, "result shown without input ready")

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);

`default_nettype wire

[test/modular_exponentiation_core_tb.sv]
// testbench for modular_exponentiation_core: directed corners, then random words, all checked
// against a square-and-multiply predictor in this file; depends on mexp_pkg and the rtl
`default_nettype none

module modular_exponentiation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 265;

  typedef struct packed {
    logic [31:0] residue;
    logic        bad_modulus;
  } residue_word_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [mexp_pkg::IN_TDATA_W-1:0]     in_tdata;   // base_value, power, divisor
  logic                                out_tvalid;
  logic                                out_tready;
  logic [mexp_pkg::OUT_TDATA_W-1:0]    out_tdata;  // residue
  logic [mexp_pkg::OUT_TUSER_W-1:0]    out_tuser;  // bad_modulus

  residue_word_t residues_due[$];
  int            mismatches;
  bit            steady_flow;  // when set neither side idles

  modular_exponentiation_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // left-to-right square and multiply, products kept exact in 64 bits
  function automatic residue_word_t power_residue(input logic [31:0] base_value,
                                                  input logic [31:0] power,
                                                  input logic [31:0] divisor);
    residue_word_t r;
    logic [63:0]   acc;
    logic [63:0]   base_red;
    logic [63:0]   modulus;
    r.residue     = '0;
    r.bad_modulus = 1'b1;
    if (divisor == 32'd0) return r;
    modulus  = {32'd0, divisor};
    acc      = 64'd1 % modulus;
    base_red = {32'd0, base_value} % modulus;
    for (int i = 31; i >= 0; i--) begin
      acc = (acc * acc) % modulus;
      if (power[i]) acc = (acc * base_red) % modulus;
    end
    r.residue     = acc[31:0];
    r.bad_modulus = 1'b0;
    return r;
  endfunction

  function automatic int idle_cycles();
    if (steady_flow) return 0;
    return $urandom_range(0, 9);
  endfunction

  // one word on the input channel; the expectation is queued at acceptance
  task automatic send_word(input logic [31:0] base_value, input logic [31:0] power,
                           input logic [31:0] divisor);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, power, base_value};
    do @(posedge clk); while (!in_tready);
    residues_due.push_back(power_residue(base_value, power, divisor));
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait on the clock before anything else drives it
  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (residues_due.size() != 0) @(posedge clk);
  endtask

  // result side: random stall before each word, ready held until the word moves
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    residue_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (residues_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: residue %0d bad_modulus %0d",
                   out_tdata, out_tuser);
      end else begin
        want = residues_due.pop_front();
        if (out_tdata !== want.residue || out_tuser[0] !== want.bad_modulus) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: residue exp %0d got %0d, bad_modulus exp %0d got %0d",
                     want.residue, out_tdata, want.bad_modulus, out_tuser);
        end
      end
    end
  end

  task automatic test_operand_extremes();
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_word(32'hFFFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFB);
    send_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001);
    send_word(32'h1234_5678, 32'h0000_0001, 32'h0000_1000);
    send_word(32'h0000_0003, 32'h0000_0004, 32'h0000_0005);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF);
    stop_input();
  endtask

  task automatic test_modulus_corners();
    // zero divisor flags an error whatever the other fields hold
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word($urandom(), $urandom(), 32'h0000_0000);
    // modulus of one always gives zero, also with a zero exponent; then a modulus of two
    send_word(32'hDEAD_BEEF, 32'h0000_0000, 32'h0000_0001);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_word(32'h0000_0007, 32'h0000_0003, 32'h0000_0002);
    // base a multiple of the divisor
    send_word(32'h0000_0063, 32'h0000_0011, 32'h0000_0021);
    stop_input();
  endtask

  task automatic test_exponent_corners();
    // zero exponent gives one for any divisor above one
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0007);
    send_word(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'h0000_0002, 32'h0000_0000, 32'h0000_0002);
    // zero base with a nonzero exponent
    send_word(32'h0000_0000, 32'h0000_0001, 32'h0000_000D);
    send_word(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // base above the divisor, single top exponent bit
    send_word(32'hFFFF_FFF0, 32'h8000_0000, 32'h0001_0001);
    stop_input();
  endtask

  task automatic test_random_mix();
    logic [31:0] b;
    logic [31:0] p;
    logic [31:0] d;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // every fortieth word starts a stretch of ten with no idling
      if (n % 40 == 0) steady_flow = 1'b1;
      if (n % 40 == 10) steady_flow = 1'b0;
      b = $urandom();
      p = $urandom();
      d = $urandom();
      case ($urandom_range(0, 15))
        0: d = 32'd0;
        1: d = 32'd1;
        2: p = 32'd0;
        3: b = 32'd0;
        4, 5: d = $urandom_range(2, 255);
        6: p = $urandom_range(0, 15);
        7: b = d;
        8: d = 32'hFFFF_FFFF - $urandom_range(0, 100);
        9: p = p & $urandom() & $urandom();  // few set bits, short run
        default: ;
      endcase
      send_word(b, p, d);
    end
    steady_flow = 1'b0;
    stop_input();
  endtask

  // sender holds off until every result is out, then sends back to back
  task automatic test_drain_then_burst();
    send_word($urandom(), $urandom(), $urandom());
    send_word($urandom(), $urandom(), 32'd0);
    stop_input();
    wait_drained();
    steady_flow = 1'b1;
    send_word($urandom(), $urandom(), $urandom());
    send_word($urandom(), $urandom_range(0, 3), $urandom());
    send_word($urandom(), $urandom(), 32'd0);
    steady_flow = 1'b0;
    stop_input();
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    mismatches  = 0;
    steady_flow = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_operand_extremes();
    test_modulus_corners();
    test_exponent_corners();
    test_drain_then_burst();
    test_random_mix();
    wait_drained();
    repeat (64) @(posedge clk);
    if (mismatches == 0)
      $display("modular_exponentiation_core_tb: done, clean");
    else
      $display("modular_exponentiation_core_tb: done, errors");
    $finish;
  end

  // worst case is about 300 words at the longest item length plus stalls; allow several times that
  initial begin
    #30_000_000;
    $display("modular_exponentiation_core_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
